### rtl/dual_quaternion_point_transform_assert.svh
// Assertion macros for the point transform RTL.
`ifndef DUAL_QUATERNION_POINT_TRANSFORM_ASSERT_SVH
`define DUAL_QUATERNION_POINT_TRANSFORM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQPT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dqpt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DQPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dqpt: next-cycle check failed");

`endif

### rtl/dqpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dqpt_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ROT_W  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUAL_W = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DUAL_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DUAL_Y = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DUAL_Z = 3'd7;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] w;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } vec_t;

  // Negation that maps the most negative value to the most positive one.
  function automatic logic signed [DATA_W-1:0] neg_sat(input logic signed [DATA_W-1:0] a);
    logic signed [DATA_W-1:0] r;
    if (a == SAT_MIN) begin
      r = SAT_MAX;
    end else begin
      r = -a;
    end
    return r;
  endfunction

  // Saturating addition of two full-range values.
  function automatic logic signed [DATA_W-1:0] add_sat(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0]   s;
    logic signed [DATA_W-1:0] r;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      r = s[DATA_W] ? SAT_MIN : SAT_MAX;
    end else begin
      r = s[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/dual_quaternion_point_transform.sv
// Dual quaternion rigid point transform, fixed point with FRAC_BITS fraction bits.
// The input channel (in_valid/in_ready, in_px/in_py/in_pz) takes one point per item;
// the result channel (out_valid/out_ready, out_qx/out_qy/out_qz) returns one
// transformed point per item, saturated to 32 bits, in the order of arrival.
// The transform lives in eight registers written through cfg_valid/cfg_ready,
// cfg_index and cfg_data; cfg_ready is always high. Registers are to be written only
// while no item is in flight; the block itself does not enforce this.
// The datapath is a four-stage pipeline: point-by-conjugate and dual terms,
// their sums, real-part products, final sums into the output register.
// An accepted item moves from stage to stage into the output register, which raises
// out_valid for its result; one item is taken in every cycle while results are
// drained, set by the 24 parallel multipliers of the first stage and 12 of the
// third.
// When the receiver stalls, items stay in their stages and in_ready falls only
// once every stage is full; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads the identity
// transform.
`timescale 1ns / 1ps
`default_nettype none

`include "dual_quaternion_point_transform_assert.svh"

module dual_quaternion_point_transform #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic signed [31:0]             in_px,
  input  wire logic signed [31:0]             in_py,
  input  wire logic signed [31:0]             in_pz,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic signed [31:0]             out_qx,
  output      logic signed [31:0]             out_qy,
  output      logic signed [31:0]             out_qz,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [dqpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  localparam int DW     = dqpt_pkg::DATA_W;
  localparam int PROD_W = 2 * DW;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int SUM_W  = TERM_W + 2;

  // Rescaled product: exact product shifted right arithmetically.
  function automatic logic signed [TERM_W-1:0] fmul(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
    logic signed [PROD_W-1:0] p;
    p = a * b;
    return $signed(p[PROD_W-1:FRAC_BITS]);
  endfunction

  // Exact sum of four rescaled terms, each added or subtracted, then saturated.
  function automatic logic signed [DW-1:0] hsum(input logic signed [TERM_W-1:0] a0,
                                                input logic signed [TERM_W-1:0] a1,
                                                input logic signed [TERM_W-1:0] a2,
                                                input logic signed [TERM_W-1:0] a3,
                                                input logic [3:0]               neg);
    logic signed [TERM_W-1:0] t [4];
    logic signed [SUM_W-1:0]  e;
    logic signed [SUM_W-1:0]  s;
    logic signed [DW-1:0]     r;
    t[0] = a0;
    t[1] = a1;
    t[2] = a2;
    t[3] = a3;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      e = {{2{t[i][TERM_W-1]}}, t[i]};
      s = neg[i] ? s - e : s + e;
    end
    if (!s[SUM_W-1] && (|s[SUM_W-2:DW-1])) begin
      r = dqpt_pkg::SAT_MAX;
    end else if (s[SUM_W-1] && !(&s[SUM_W-2:DW-1])) begin
      r = dqpt_pkg::SAT_MIN;
    end else begin
      r = s[DW-1:0];
    end
    return r;
  endfunction

  dqpt_pkg::quat_t rot;
  dqpt_pkg::quat_t dual;
  dqpt_pkg::quat_t rc;
  logic signed [DW-1:0] dn_w;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  dqpt_cfg_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rot       (rot),
    .dual      (dual)
  );

  // Conjugate of the real part and negated dual scalar, held static between writes.
  assign rc.w = rot.w;
  assign rc.x = dqpt_pkg::neg_sat(rot.x);
  assign rc.y = dqpt_pkg::neg_sat(rot.y);
  assign rc.z = dqpt_pkg::neg_sat(rot.z);
  assign dn_w = dqpt_pkg::neg_sat(dual.w);

  // Pipeline handshake: a stage takes a new item when empty or when it drains.
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r     : v2_r;
  assign v3_nxt = rdy3 ? v2_r     : v3_r;
  assign v4_nxt = rdy4 ? v3_r     : v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // Stage 1: terms of point * conj(real) (rows w, x, y, z) and dual * conj(real)
  // (rows x, y, z).
  logic signed [TERM_W-1:0] h1_term_nxt [12];
  logic signed [TERM_W-1:0] h3_term_nxt [12];
  logic signed [TERM_W-1:0] h1_term_r   [12];
  logic signed [TERM_W-1:0] h3_term_r   [12];

  always_comb begin
    h1_term_nxt[0]  = fmul(in_px, rc.x);
    h1_term_nxt[1]  = fmul(in_py, rc.y);
    h1_term_nxt[2]  = fmul(in_pz, rc.z);
    h1_term_nxt[3]  = fmul(in_px, rc.w);
    h1_term_nxt[4]  = fmul(in_py, rc.z);
    h1_term_nxt[5]  = fmul(in_pz, rc.y);
    h1_term_nxt[6]  = fmul(in_px, rc.z);
    h1_term_nxt[7]  = fmul(in_py, rc.w);
    h1_term_nxt[8]  = fmul(in_pz, rc.x);
    h1_term_nxt[9]  = fmul(in_px, rc.y);
    h1_term_nxt[10] = fmul(in_py, rc.x);
    h1_term_nxt[11] = fmul(in_pz, rc.w);

    h3_term_nxt[0]  = fmul(dual.w, rc.x);
    h3_term_nxt[1]  = fmul(dual.x, rc.w);
    h3_term_nxt[2]  = fmul(dual.y, rc.z);
    h3_term_nxt[3]  = fmul(dual.z, rc.y);
    h3_term_nxt[4]  = fmul(dual.w, rc.y);
    h3_term_nxt[5]  = fmul(dual.x, rc.z);
    h3_term_nxt[6]  = fmul(dual.y, rc.w);
    h3_term_nxt[7]  = fmul(dual.z, rc.x);
    h3_term_nxt[8]  = fmul(dual.w, rc.z);
    h3_term_nxt[9]  = fmul(dual.x, rc.y);
    h3_term_nxt[10] = fmul(dual.y, rc.x);
    h3_term_nxt[11] = fmul(dual.z, rc.w);
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      h1_term_r <= h1_term_nxt;
      h3_term_r <= h3_term_nxt;
    end
  end

  // Stage 2: t = -conj(dual) + point * conj(real), and the dual * conj(real) vector.
  dqpt_pkg::quat_t t_nxt, t_r;
  dqpt_pkg::vec_t  h3_nxt, h3_s2_r, h3_s3_r;

  always_comb begin
    t_nxt.w = dqpt_pkg::add_sat(dn_w,
                hsum('0, h1_term_r[0], h1_term_r[1], h1_term_r[2], 4'b1110));
    t_nxt.x = dqpt_pkg::add_sat(dual.x,
                hsum('0, h1_term_r[3], h1_term_r[4], h1_term_r[5], 4'b1000));
    t_nxt.y = dqpt_pkg::add_sat(dual.y,
                hsum('0, h1_term_r[6], h1_term_r[7], h1_term_r[8], 4'b0010));
    t_nxt.z = dqpt_pkg::add_sat(dual.z,
                hsum('0, h1_term_r[9], h1_term_r[10], h1_term_r[11], 4'b0100));

    h3_nxt.x = hsum(h3_term_r[0], h3_term_r[1], h3_term_r[2], h3_term_r[3], 4'b1000);
    h3_nxt.y = hsum(h3_term_r[4], h3_term_r[5], h3_term_r[6], h3_term_r[7], 4'b0010);
    h3_nxt.z = hsum(h3_term_r[8], h3_term_r[9], h3_term_r[10], h3_term_r[11], 4'b0100);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      t_r     <= t_nxt;
      h3_s2_r <= h3_nxt;
    end
  end

  // Stage 3: terms of real * t (rows x, y, z); the dual vector travels alongside.
  logic signed [TERM_W-1:0] h2_term_nxt [12];
  logic signed [TERM_W-1:0] h2_term_r   [12];

  always_comb begin
    h2_term_nxt[0]  = fmul(rot.w, t_r.x);
    h2_term_nxt[1]  = fmul(rot.x, t_r.w);
    h2_term_nxt[2]  = fmul(rot.y, t_r.z);
    h2_term_nxt[3]  = fmul(rot.z, t_r.y);
    h2_term_nxt[4]  = fmul(rot.w, t_r.y);
    h2_term_nxt[5]  = fmul(rot.x, t_r.z);
    h2_term_nxt[6]  = fmul(rot.y, t_r.w);
    h2_term_nxt[7]  = fmul(rot.z, t_r.x);
    h2_term_nxt[8]  = fmul(rot.w, t_r.z);
    h2_term_nxt[9]  = fmul(rot.x, t_r.y);
    h2_term_nxt[10] = fmul(rot.y, t_r.x);
    h2_term_nxt[11] = fmul(rot.z, t_r.w);
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      h2_term_r <= h2_term_nxt;
      h3_s3_r   <= h3_s2_r;
    end
  end

  // Stage 4: output register holds the dual vector part of the result.
  dqpt_pkg::vec_t res_nxt, res_r;

  always_comb begin
    res_nxt.x = dqpt_pkg::add_sat(
                  hsum(h2_term_r[0], h2_term_r[1], h2_term_r[2], h2_term_r[3], 4'b1000),
                  h3_s3_r.x);
    res_nxt.y = dqpt_pkg::add_sat(
                  hsum(h2_term_r[4], h2_term_r[5], h2_term_r[6], h2_term_r[7], 4'b0010),
                  h3_s3_r.y);
    res_nxt.z = dqpt_pkg::add_sat(
                  hsum(h2_term_r[8], h2_term_r[9], h2_term_r[10], h2_term_r[11], 4'b0100),
                  h3_s3_r.z);
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_qx    = res_r.x;
  assign out_qy    = res_r.y;
  assign out_qz    = res_r.z;

  // An empty output register always lets the whole pipeline advance.
  `DQPT_ASSERT_SAME(a_empty_out_ready, clk, rst_n, !v4_r, in_ready)
  // A full pipeline with a stalled receiver refuses new items.
  `DQPT_ASSERT_SAME(a_full_stall_block, clk, rst_n,
                    v1_r && v2_r && v3_r && v4_r && !out_ready, !in_ready)
  // An item held in the first stage is not lost while the next stage is blocked.
  `DQPT_ASSERT_NEXT(a_stage1_hold, clk, rst_n, v1_r && !rdy2, v1_r)

endmodule

`default_nettype wire

### rtl/dqpt_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module dqpt_cfg_regs #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [dqpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dqpt_pkg::DATA_W-1:0]    cfg_data,
  output      dqpt_pkg::quat_t                rot,
  output      dqpt_pkg::quat_t                dual
);

  // Unit value in the chosen fixed-point format.
  localparam logic [dqpt_pkg::DATA_W-1:0] ONE_Q =
    {{(dqpt_pkg::DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  dqpt_pkg::quat_t rot_r;
  dqpt_pkg::quat_t dual_r;

  // Register file: identity transform after reset, one word per write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r  <= '{w: ONE_Q, x: '0, y: '0, z: '0};
      dual_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dqpt_pkg::REG_ROT_W:  rot_r.w  <= cfg_data;
        dqpt_pkg::REG_ROT_X:  rot_r.x  <= cfg_data;
        dqpt_pkg::REG_ROT_Y:  rot_r.y  <= cfg_data;
        dqpt_pkg::REG_ROT_Z:  rot_r.z  <= cfg_data;
        dqpt_pkg::REG_DUAL_W: dual_r.w <= cfg_data;
        dqpt_pkg::REG_DUAL_X: dual_r.x <= cfg_data;
        dqpt_pkg::REG_DUAL_Y: dual_r.y <= cfg_data;
        dqpt_pkg::REG_DUAL_Z: dual_r.z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rot  = rot_r;
  assign dual = dual_r;

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int FRAC        = 16;
  localparam int LATENCY     = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;
  localparam longint LIMIT   = 400000;

  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] ZERO = 32'sd0;

  // Ways in which the receiver decides to take a result.
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  // Keeps a copy of the transform registers, works out the transformed point
  // for every accepted item and compares the results in order of arrival.
  class transform_checker;
    dqpt_pkg::quat_t rot_q;
    dqpt_pkg::quat_t dual_q;
    dqpt_pkg::vec_t  expected_points[$];
    int              mismatches;
    int              results_seen;

    function new();
      rot_q        = {ONE, ZERO, ZERO, ZERO};
      dual_q       = {ZERO, ZERO, ZERO, ZERO};
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [dqpt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        dqpt_pkg::REG_ROT_W:  rot_q.w  = data;
        dqpt_pkg::REG_ROT_X:  rot_q.x  = data;
        dqpt_pkg::REG_ROT_Y:  rot_q.y  = data;
        dqpt_pkg::REG_ROT_Z:  rot_q.z  = data;
        dqpt_pkg::REG_DUAL_W: dual_q.w = data;
        dqpt_pkg::REG_DUAL_X: dual_q.x = data;
        dqpt_pkg::REG_DUAL_Y: dual_q.y = data;
        dqpt_pkg::REG_DUAL_Z: dual_q.z = data;
        default: ;
      endcase
    endfunction

    function logic signed [31:0] sat32(longint v);
      if (v > longint'(dqpt_pkg::SAT_MAX)) return dqpt_pkg::SAT_MAX;
      if (v < longint'(dqpt_pkg::SAT_MIN)) return dqpt_pkg::SAT_MIN;
      return v[31:0];
    endfunction

    // Full 64-bit product, rescaled by an arithmetic shift (rounds down).
    function longint fmul(longint a, longint b);
      return (a * b) >>> FRAC;
    endfunction

    function dqpt_pkg::quat_t hamilton(dqpt_pkg::quat_t a, dqpt_pkg::quat_t b);
      longint          aw, ax, ay, az, bw, bx, by, bz;
      dqpt_pkg::quat_t r;
      aw = a.w; ax = a.x; ay = a.y; az = a.z;
      bw = b.w; bx = b.x; by = b.y; bz = b.z;
      r.w = sat32(fmul(aw, bw) - fmul(ax, bx) - fmul(ay, by) - fmul(az, bz));
      r.x = sat32(fmul(aw, bx) + fmul(ax, bw) + fmul(ay, bz) - fmul(az, by));
      r.y = sat32(fmul(aw, by) - fmul(ax, bz) + fmul(ay, bw) + fmul(az, bx));
      r.z = sat32(fmul(aw, bz) + fmul(ax, by) - fmul(ay, bx) + fmul(az, bw));
      return r;
    endfunction

    function dqpt_pkg::quat_t qadd(dqpt_pkg::quat_t a, dqpt_pkg::quat_t b);
      dqpt_pkg::quat_t r;
      r.w = sat32(longint'(a.w) + longint'(b.w));
      r.x = sat32(longint'(a.x) + longint'(b.x));
      r.y = sat32(longint'(a.y) + longint'(b.y));
      r.z = sat32(longint'(a.z) + longint'(b.z));
      return r;
    endfunction

    // The point enters as (1, eps*p); the unit real part needs no product.
    function void note_input(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
      dqpt_pkg::quat_t rc, dn, p, t, res;
      dqpt_pkg::vec_t  e;
      rc  = {rot_q.w, sat32(-longint'(rot_q.x)), sat32(-longint'(rot_q.y)),
             sat32(-longint'(rot_q.z))};
      dn  = {sat32(-longint'(dual_q.w)), dual_q.x, dual_q.y, dual_q.z};
      p   = {ZERO, px, py, pz};
      t   = qadd(dn, hamilton(p, rc));
      res = qadd(hamilton(rot_q, t), hamilton(dual_q, rc));
      e   = {res.x, res.y, res.z};
      expected_points.push_back(e);
    endfunction

    function void check_result(logic signed [31:0] qx, logic signed [31:0] qy,
                               logic signed [31:0] qz);
      dqpt_pkg::vec_t e;
      results_seen++;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result (%0d, %0d, %0d) with no item waiting", qx, qy, qz);
      end else begin
        e = expected_points.pop_front();
        if (qx !== e.x || qy !== e.y || qz !== e.z) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Mismatch on result %0d: expected (%0d, %0d, %0d), got (%0d, %0d, %0d)",
                     results_seen, e.x, e.y, e.z, qx, qy, qz);
        end
      end
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  logic signed [31:0]             in_px     = '0;
  logic signed [31:0]             in_py     = '0;
  logic signed [31:0]             in_pz     = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [31:0]             out_qx;
  logic signed [31:0]             out_qy;
  logic signed [31:0]             out_qz;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [dqpt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                    cfg_data  = '0;

  transform_checker xform = new();
  int     items_sent       = 0;
  int     settings_applied = 0;
  int     reg_writes       = 0;
  bit     hold_req         = 1'b0;
  longint cycle_count      = 0;

  dual_quaternion_point_transform #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_px     (in_px),
    .in_py     (in_py),
    .in_pz     (in_pz),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_qx    (out_qx),
    .out_qy    (out_qy),
    .out_qz    (out_qz),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAIL dual_quaternion_point_transform");
      $finish;
    end
  end

  // Observe every handshake on the three channels.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) xform.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) xform.note_input(in_px, in_py, in_pz);
      if (out_valid && out_ready) xform.check_result(out_qx, out_qy, out_qz);
    end
  end

  // Receiver: segments of differing stall patterns, plus a long hold-off on request.
  initial begin
    int       seg_len;
    int       hold_left;
    int       tick;
    bit       rdy;
    rx_mode_t mode;
    hold_left = 0;
    tick      = 0;
    forever begin
      seg_len = $urandom_range(8, 120);
      mode    = rx_mode_t'($urandom_range(0, 3));
      repeat (seg_len) begin
        if (hold_req) begin
          hold_left = HOLD_CYCLES;
          hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
          rdy = 1'b0;
          hold_left--;
        end else begin
          case (mode)
            RX_ALWAYS:   rdy = 1'b1;
            RX_RANDOM:   rdy = $urandom_range(0, 1);
            RX_SPARSE:   rdy = ($urandom_range(0, 3) == 0);
            default:     rdy = ((tick % 4) != 3);
          endcase
        end
        tick++;
        out_ready <= rdy;
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic [dqpt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  task automatic apply_setting(input dqpt_pkg::quat_t r, input dqpt_pkg::quat_t d);
    write_reg(dqpt_pkg::REG_ROT_W, r.w);
    write_reg(dqpt_pkg::REG_ROT_X, r.x);
    write_reg(dqpt_pkg::REG_ROT_Y, r.y);
    write_reg(dqpt_pkg::REG_ROT_Z, r.z);
    write_reg(dqpt_pkg::REG_DUAL_W, d.w);
    write_reg(dqpt_pkg::REG_DUAL_X, d.x);
    write_reg(dqpt_pkg::REG_DUAL_Y, d.y);
    write_reg(dqpt_pkg::REG_DUAL_Z, d.z);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // Offer one item and hold it until the block takes it.
  task automatic drive_point(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z);
    in_valid <= 1'b1;
    in_px    <= x;
    in_py    <= y;
    in_pz    <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every item has come back, then let the pipe settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (xform.results_seen < items_sent) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] small_value(int half_range);
    return int'($urandom_range(0, 2 * half_range)) - half_range;
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(0, 5))
      0:       return dqpt_pkg::SAT_MIN;
      1:       return dqpt_pkg::SAT_MAX;
      2:       return ZERO;
      3:       return ONE;
      4:       return -ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return small_value(100 << 16);
      7:          return small_value(1 << 24);
      default:    return pick_extreme();
    endcase
  endfunction

  // A unit rotation from a random direction in four dimensions.
  function automatic dqpt_pkg::quat_t random_rotation();
    real             a, b, c, e, n;
    dqpt_pkg::quat_t q;
    a = real'(int'($urandom_range(0, 2000)) - 1000);
    b = real'(int'($urandom_range(0, 2000)) - 1000);
    c = real'(int'($urandom_range(0, 2000)) - 1000);
    e = real'(int'($urandom_range(0, 2000)) - 1000);
    n = $sqrt(a * a + b * b + c * c + e * e);
    if (n < 1.0) begin
      q = {ONE, ZERO, ZERO, ZERO};
    end else begin
      q = {int'(a / n * 65536.0), int'(b / n * 65536.0), int'(c / n * 65536.0),
           int'(e / n * 65536.0)};
    end
    return q;
  endfunction

  // Random points, gapless or in bursts of random length with random gaps between them.
  task automatic send_points(input int n, input bit gapless);
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 24);
    repeat (n) begin
      drive_point(random_coord(), random_coord(), random_coord());
      if (!gapless) begin
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end
  endtask

  initial begin
    dqpt_pkg::quat_t r, d;
    int              k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity transform straight out of reset: every point comes back as it went in.
    drive_point(ZERO, ZERO, ZERO);
    drive_point(dqpt_pkg::SAT_MAX, dqpt_pkg::SAT_MAX, dqpt_pkg::SAT_MAX);
    drive_point(dqpt_pkg::SAT_MIN, dqpt_pkg::SAT_MIN, dqpt_pkg::SAT_MIN);
    drive_point(dqpt_pkg::SAT_MAX, dqpt_pkg::SAT_MIN, ZERO);
    drive_point(ONE, -ONE, ONE / 2);
    drive_point(32'sd1, -32'sd1, 32'sh0001_8000);
    wait_drained();

    // Quarter turn about z with an offset.
    apply_setting({32'sd46341, ZERO, ZERO, 32'sd46341},
                  {-ONE, 32'sh0002_8000, -(3 * ONE), ONE / 4});
    drive_point(ONE, ZERO, ZERO);
    drive_point(ZERO, ONE, ZERO);
    drive_point(10 * ONE, -(7 * ONE), 3 * ONE);
    drive_point(dqpt_pkg::SAT_MAX, dqpt_pkg::SAT_MAX, dqpt_pkg::SAT_MIN);
    drive_point(-32'sd1, 32'sd1, -32'sd1);
    wait_drained();

    // Every register at the most negative value: heavy intermediate saturation.
    apply_setting({dqpt_pkg::SAT_MIN, dqpt_pkg::SAT_MIN, dqpt_pkg::SAT_MIN,
                   dqpt_pkg::SAT_MIN},
                  {dqpt_pkg::SAT_MIN, dqpt_pkg::SAT_MIN, dqpt_pkg::SAT_MIN,
                   dqpt_pkg::SAT_MIN});
    drive_point(ZERO, ZERO, ZERO);
    drive_point(dqpt_pkg::SAT_MAX, dqpt_pkg::SAT_MIN, dqpt_pkg::SAT_MAX);
    drive_point(ONE, ONE, -ONE);
    wait_drained();

    // Every register at the most positive value.
    apply_setting({dqpt_pkg::SAT_MAX, dqpt_pkg::SAT_MAX, dqpt_pkg::SAT_MAX,
                   dqpt_pkg::SAT_MAX},
                  {dqpt_pkg::SAT_MAX, dqpt_pkg::SAT_MAX, dqpt_pkg::SAT_MAX,
                   dqpt_pkg::SAT_MAX});
    drive_point(ZERO, ZERO, ZERO);
    drive_point(dqpt_pkg::SAT_MIN, dqpt_pkg::SAT_MIN, dqpt_pkg::SAT_MIN);
    drive_point(-ONE, ONE, ONE);
    wait_drained();

    // Conjugation and negation of the most negative value, unnormalised transform.
    apply_setting({ONE, dqpt_pkg::SAT_MIN, dqpt_pkg::SAT_MIN, dqpt_pkg::SAT_MIN},
                  {dqpt_pkg::SAT_MIN, ZERO, ZERO, ZERO});
    drive_point(ZERO, ZERO, ZERO);
    drive_point(ONE, -ONE, ONE);
    drive_point(dqpt_pkg::SAT_MIN, dqpt_pkg::SAT_MAX, ZERO);
    wait_drained();

    // Random settings, each followed by a stream of random points.
    for (k = 0; k < 10; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          r = random_rotation();
          d = {small_value(50 << 16), small_value(50 << 16), small_value(50 << 16),
               small_value(50 << 16)};
        end
        6, 7: begin
          r = {$urandom, $urandom, $urandom, $urandom};
          d = {$urandom, $urandom, $urandom, $urandom};
        end
        default: begin
          r = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
          d = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
        end
      endcase
      apply_setting(r, d);
      if (k == 3) begin
        // The receiver holds off while items keep coming, so the pipe fills and stalls.
        hold_req = 1'b1;
        send_points(40, 1'b1);
        send_points(25, 1'b0);
      end else begin
        send_points(65, 1'b0);
      end
      wait_drained();
    end

    $display("Checked %0d results from %0d points under %0d register settings.",
             xform.results_seen, items_sent, settings_applied);
    $display("Register writes: %0d; identity, extreme, rotation and random transforms used.",
             reg_writes);
    if (xform.mismatches == 0 && xform.expected_points.size() == 0) begin
      $display("PASS dual_quaternion_point_transform");
    end else begin
      $display("%0d mismatches, %0d results never arrived", xform.mismatches,
               xform.expected_points.size());
      $display("FAIL dual_quaternion_point_transform");
    end
    $finish;
  end

endmodule
